// File: hw/rtl/assert_macros.svh
// assertion helpers, sampled on clk and disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define GWS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define GWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/gws_pkg.sv
package gws_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // phase codes, same encoding as new_state and state_code
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_UNWIND = 3'd1;
  localparam logic [2:0] PH_LOWER  = 3'd2;
  localparam logic [2:0] PH_WIND   = 3'd3;
  localparam logic [2:0] PH_RAISE  = 3'd4;

  // winch drive codes
  localparam logic [1:0] DRV_STOP   = 2'd0;
  localparam logic [1:0] DRV_UNWIND = 2'd1;
  localparam logic [1:0] DRV_WIND   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UNWIND_TICKS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIND_TICKS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVO_TICKS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EARLY_TICKS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_PULSE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RAISE_PULSE   = 3'd6;

  // reset values
  localparam logic [15:0] RST_UNWIND_TICKS  = 16'd1000;
  localparam logic [15:0] RST_WIND_TICKS    = 16'd1000;
  localparam logic [15:0] RST_SERVO_TICKS   = 16'd500;
  localparam logic [15:0] RST_EARLY_TICKS   = 16'd10;
  localparam logic [11:0] RST_CURRENT_LIMIT = 12'd2048;
  localparam logic [11:0] RST_LOWER_PULSE   = 12'd800;
  localparam logic [11:0] RST_RAISE_PULSE   = 12'd1200;

  typedef struct packed {
    logic        command;
    logic [2:0]  new_state;
    logic [11:0] current_sample;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  state_code;
    logic [1:0]  motor_drive;
    logic [11:0] servo_command;
    logic        grip_success;
  } out_item_t;

  typedef struct packed {
    logic [15:0] unwind_ticks;
    logic [15:0] wind_ticks;
    logic [15:0] servo_ticks;
    logic [15:0] early_motor_ticks;
    logic [11:0] current_limit;
    logic [11:0] lower_pulse;
    logic [11:0] raise_pulse;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] unwind_left;
    logic [15:0] wind_left;
    logic [15:0] servo_left;
    logic [1:0]  drive_held;
    logic [11:0] servo_held;
    logic        success_flag;
  } seq_state_t;

endpackage

// File: hw/rtl/gws_cfg.sv
module gws_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [gws_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gws_pkg::CFG_DATA_W-1:0]  cfg_data,
  output gws_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.unwind_ticks      <= gws_pkg::RST_UNWIND_TICKS;
      cfg.wind_ticks        <= gws_pkg::RST_WIND_TICKS;
      cfg.servo_ticks       <= gws_pkg::RST_SERVO_TICKS;
      cfg.early_motor_ticks <= gws_pkg::RST_EARLY_TICKS;
      cfg.current_limit     <= gws_pkg::RST_CURRENT_LIMIT;
      cfg.lower_pulse       <= gws_pkg::RST_LOWER_PULSE;
      cfg.raise_pulse       <= gws_pkg::RST_RAISE_PULSE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        gws_pkg::CFG_UNWIND_TICKS:  cfg.unwind_ticks      <= cfg_data;
        gws_pkg::CFG_WIND_TICKS:    cfg.wind_ticks        <= cfg_data;
        gws_pkg::CFG_SERVO_TICKS:   cfg.servo_ticks       <= cfg_data;
        gws_pkg::CFG_EARLY_TICKS:   cfg.early_motor_ticks <= cfg_data;
        gws_pkg::CFG_CURRENT_LIMIT: cfg.current_limit     <= cfg_data[11:0];
        gws_pkg::CFG_LOWER_PULSE:   cfg.lower_pulse       <= cfg_data[11:0];
        gws_pkg::CFG_RAISE_PULSE:   cfg.raise_pulse       <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/gws_step.sv
module gws_step (
  input  gws_pkg::seq_state_t cur,
  input  gws_pkg::in_item_t   item,
  input  gws_pkg::cfg_t       cfg,
  output gws_pkg::seq_state_t nxt
);

  logic [15:0] unwind_dec;
  logic [15:0] wind_dec;
  logic [15:0] servo_dec;

  assign unwind_dec = cur.unwind_left - 16'd1;
  assign wind_dec   = cur.wind_left - 16'd1;
  assign servo_dec  = cur.servo_left - 16'd1;

  always_comb begin
    nxt = cur;
    if (item.command) begin
      // forced phase, timers and outputs untouched
      nxt.phase = item.new_state;
    end else begin
      case (cur.phase)
        gws_pkg::PH_UNWIND: begin
          nxt.unwind_left = unwind_dec;
          nxt.drive_held  = gws_pkg::DRV_UNWIND;
          if (unwind_dec == 16'd0) begin
            nxt.drive_held  = gws_pkg::DRV_STOP;
            nxt.unwind_left = cfg.unwind_ticks;
            nxt.wind_left   = cfg.wind_ticks;
            nxt.phase       = gws_pkg::PH_LOWER;
          end
        end
        gws_pkg::PH_LOWER: begin
          nxt.servo_held = cfg.lower_pulse;
          nxt.servo_left = servo_dec;
          if (servo_dec == 16'd0) begin
            nxt.servo_left = cfg.servo_ticks;
            nxt.phase      = gws_pkg::PH_WIND;
          end else if (servo_dec <= cfg.early_motor_ticks) begin
            nxt.drive_held = gws_pkg::DRV_WIND;
          end
        end
        gws_pkg::PH_WIND: begin
          nxt.wind_left  = wind_dec;
          nxt.drive_held = gws_pkg::DRV_WIND;
          if (wind_dec == 16'd0) begin
            nxt.drive_held   = gws_pkg::DRV_STOP;
            nxt.unwind_left  = cfg.unwind_ticks;
            nxt.wind_left    = cfg.wind_ticks;
            nxt.phase        = gws_pkg::PH_IDLE;
            nxt.success_flag = 1'b0;
          end else if (item.current_sample >= cfg.current_limit) begin
            // wind timer keeps its partial count here
            nxt.drive_held   = gws_pkg::DRV_STOP;
            nxt.unwind_left  = cfg.unwind_ticks;
            nxt.phase        = gws_pkg::PH_IDLE;
            nxt.success_flag = 1'b1;
          end
        end
        gws_pkg::PH_RAISE: begin
          nxt.drive_held = gws_pkg::DRV_STOP;
          nxt.servo_held = cfg.raise_pulse;
          nxt.servo_left = servo_dec;
          if (servo_dec == 16'd0) begin
            nxt.servo_left = cfg.servo_ticks;
            nxt.phase      = gws_pkg::PH_UNWIND;
          end else if (servo_dec <= cfg.early_motor_ticks) begin
            nxt.drive_held = gws_pkg::DRV_UNWIND;
          end
        end
        default: begin
          // idle and unused codes
          nxt.drive_held = gws_pkg::DRV_STOP;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/gripper_winch_sequencer.sv
// Gripper winch sequencer: each input transaction is either one control tick or a
// forced phase change, and produces exactly one result transaction carrying the phase,
// the held winch drive, the held servo command and the grip success flag after that
// item. The sequencer state and the result register both update at the accepting edge,
// the result appears on out_data in the cycle after acceptance, and a new item is
// accepted every cycle as long as the result register is empty or being taken
// (in_stall is high only while a result waits under out_stall). Timer count writes take
// effect at the next timer reload; the other configuration fields apply on each tick.
`include "assert_macros.svh"

module gripper_winch_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [gws_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gws_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  gws_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output gws_pkg::out_item_t              out_data
);

  gws_pkg::cfg_t       cfg;
  gws_pkg::seq_state_t seq;
  gws_pkg::seq_state_t seq_next;
  logic                in_acc;

  gws_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gws_step u_step (
    .cur  (seq),
    .item (in_data),
    .cfg  (cfg),
    .nxt  (seq_next)
  );

  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq.phase        <= gws_pkg::PH_IDLE;
      seq.unwind_left  <= gws_pkg::RST_UNWIND_TICKS;
      seq.wind_left    <= gws_pkg::RST_WIND_TICKS;
      seq.servo_left   <= gws_pkg::RST_SERVO_TICKS;
      seq.drive_held   <= gws_pkg::DRV_WIND;
      seq.servo_held   <= 12'd0;
      seq.success_flag <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (in_acc) begin
        seq       <= seq_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted transaction
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data.state_code    <= seq_next.phase;
      out_data.motor_drive   <= seq_next.drive_held;
      out_data.servo_command <= seq_next.servo_held;
      out_data.grip_success  <= seq_next.success_flag;
    end
  end

  `GWS_ASSERT_NEXT(a_force_phase, in_acc && in_data.command, out_valid && out_data.state_code == $past(in_data.new_state), "forced phase not reported")

  `GWS_ASSERT_SAME(a_drive_code, out_valid, out_data.motor_drive == gws_pkg::DRV_STOP || out_data.motor_drive == gws_pkg::DRV_UNWIND || out_data.motor_drive == gws_pkg::DRV_WIND, "illegal drive code")

  `GWS_ASSERT_SAME(a_success_idle, $rose(seq.success_flag), seq.phase == gws_pkg::PH_IDLE && seq.drive_held == gws_pkg::DRV_STOP, "success set outside wind exit")

endmodule
